/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes, field widths and controller/datapath interface types for the
// sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int OP_W     = 2;
    localparam int IN_TAG_W = 32;
    localparam int IN_PRI_W = 16;
    localparam int OUT_TAG_W = 32;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE  = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic load_in;
        logic remove;
        logic insert;
        logic load_out;
    } spq_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } spq_sts_t;

endpackage

/* rtl/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: accept, remove phase, insert phase (insert and update only), result hand-off.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output spq_cmd_t cmd,
    input  spq_sts_t sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_REM  = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_REM;
                end
            end
            S_REM: begin
                cmd.remove = 1'b1;
                if (sts.op == OP_INSERT || sts.op == OP_UPDATE) begin
                    state_next = S_INS;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_INS: begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

/* rtl/spq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted entry row with parallel match/compare and one-step shift per phase,
// plus the request and result registers.
// ----------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int TAG_BITS  = 32,
    parameter int PRIO_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  spq_cmd_t             cmd,
    output spq_sts_t             sts
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam longint PMAX_L = (64'sd1 <<< (PRIO_BITS - 1)) - 64'sd1;
    localparam longint PMIN_L = -PMAX_L - 64'sd1;
    localparam logic signed [32:0] PMAX = 33'(PMAX_L);
    localparam logic signed [32:0] PMIN = 33'(PMIN_L);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [TAG_BITS-1:0]         tags_reg  [DEPTH];
    logic [TAG_BITS-1:0]         tags_next [DEPTH];
    logic signed [PRIO_BITS-1:0] prios_reg [DEPTH];
    logic signed [PRIO_BITS-1:0] prios_next[DEPTH];
    logic [CW-1:0]               count_reg, count_next;

    logic [OP_W-1:0]             op_reg;
    logic [TAG_BITS-1:0]         key_reg;
    logic signed [PRIO_BITS-1:0] pri_reg;
    logic [TAG_BITS-1:0]         otag_reg;
    logic [STAT_W-1:0]           stat_reg;
    logic [M_TDATA_W-1:0]        mdata_reg;

    logic [63:0]                 tag_wide;
    logic signed [32:0]          pri_wide, pri_sat;
    logic [DEPTH-1:0]            valid, match, after, ge;
    logic                        found;
    logic [63:0]                 otag_wide, cnt_wide;

    assign tag_wide = {32'b0, s_tdata[OP_W +: IN_TAG_W]};
    assign pri_wide = 33'(signed'(s_tdata[OP_W+IN_TAG_W +: IN_PRI_W]));

    always_comb begin
        if (pri_wide > PMAX) begin
            pri_sat = PMAX;
        end else if (pri_wide < PMIN) begin
            pri_sat = PMIN;
        end else begin
            pri_sat = pri_wide;
        end
    end

    always_comb begin
        logic [DEPTH-1:0] lowmask;
        for (int i = 0; i < DEPTH; i++) begin
            valid[i] = (CW'(i) < count_reg);
            if (op_reg == OP_EXTRACT) begin
                match[i] = (i == 0) && valid[i];
            end else if (op_reg == OP_INSERT) begin
                match[i] = 1'b0;
            end else begin
                match[i] = valid[i] && (tags_reg[i] == key_reg);
            end
            ge[i] = !valid[i] || (prios_reg[i] >= pri_reg);
        end
        for (int i = 0; i < DEPTH; i++) begin
            for (int j = 0; j < DEPTH; j++) begin
                lowmask[j] = (j <= i);
            end
            after[i] = |(match & lowmask);
        end
        found = |match;
    end

    always_comb begin
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++) begin
            tags_next[i]  = tags_reg[i];
            prios_next[i] = prios_reg[i];
        end
        if (cmd.remove) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (after[i]) begin
                    tags_next[i]  = tags_reg[i+1];
                    prios_next[i] = prios_reg[i+1];
                end
            end
            if (found) begin
                count_next = count_reg - 1'b1;
            end
        end else if (cmd.insert && count_reg != FULL_CNT) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (ge[i]) begin
                    if (i == 0) begin
                        tags_next[i]  = key_reg;
                        prios_next[i] = pri_reg;
                    end else if (!ge[i-1]) begin
                        tags_next[i]  = key_reg;
                        prios_next[i] = pri_reg;
                    end else begin
                        tags_next[i]  = tags_reg[i-1];
                        prios_next[i] = prios_reg[i-1];
                    end
                end
            end
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            tags_reg[i]  <= tags_next[i];
            prios_reg[i] <= prios_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= s_tdata[OP_W-1:0];
            key_reg  <= tag_wide[TAG_BITS-1:0];
            pri_reg  <= pri_sat[PRIO_BITS-1:0];
            otag_reg <= '0;
            stat_reg <= ST_OK;
        end else if (cmd.remove) begin
            if (op_reg == OP_EXTRACT && found) begin
                otag_reg <= tags_reg[0];
            end
            if (op_reg != OP_INSERT && !found) begin
                if (op_reg == OP_UPDATE || count_reg != '0) begin
                    stat_reg <= ST_NOTFOUND;
                end else begin
                    stat_reg <= ST_EMPTY;
                end
            end
        end else if (cmd.insert && count_reg == FULL_CNT) begin
            stat_reg <= ST_FULL;
        end
    end

    assign otag_wide = 64'(otag_reg);
    assign cnt_wide  = 64'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            mdata_reg <= {1'b0, cnt_wide[CNT_W-1:0], stat_reg, otag_wide[OUT_TAG_W-1:0]};
        end
    end

    assign m_tdata = mdata_reg;
    assign sts.op  = op_reg;

endmodule

/* rtl/sorted_priority_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Priority queue of up to DEPTH tagged entries kept in ascending order.
// ----------------------------------------------------------------------------
// Each item carries an opcode (insert, extract_min, update, remove by tag), a
// tag and a signed Q8.8 priority, and yields one result item: extracted tag,
// status and entry count. Entries sit in a register row that matches all tags
// or compares all priorities in parallel and shifts by one place per cycle.
// An item for extract_min or remove runs accept, remove pass and result
// load; insert or update adds an insert pass before the result load.
// The result sits in an output register, so a stalled result only holds the
// block once the next item is finished.
// No clearing pass after reset; entries past the count are never read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int TAG_BITS  = 32,
    parameter int PRIO_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // opcode[1:0], tag[33:2], priority_req[49:34]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // out_tag[31:0], status[33:32], count[38:34]
);

    spq_cmd_t cmd;
    spq_sts_t sts;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    spq_datapath #(
        .DEPTH     (DEPTH),
        .TAG_BITS  (TAG_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
